// ----- rtl/bcpm_pkg.sv -----
// Shared types and constants for the brightness/contrast pixel map.
`default_nettype none
package bcpm_pkg;

    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 10;
    localparam int EN_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int LATENCY = 4;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_FORMAT    = 4'd3;

    // Channel enable bit positions
    localparam int EN_RED   = 0;
    localparam int EN_GREEN = 1;
    localparam int EN_BLUE  = 2;
    localparam int EN_GRAY  = 3;

    // Unity gain in 1/256 units, offset 0.5 scaled by 2*256*255/2, full scale
    localparam logic signed [10:0] UNITY      = 11'sd256;
    localparam logic signed [20:0] MID_OFFSET = 21'sd65280;
    localparam logic signed [31:0] MAP_DEN    = 32'sd33423360;

    typedef struct packed {
        logic signed [GAIN_W-1:0] brightness;
        logic signed [GAIN_W-1:0] contrast;
        logic [EN_W-1:0]          channel_enable;
        logic                     gray_format;
    } t_cfg;

    // Side-band data that travels beside the channel lanes
    typedef struct packed {
        logic             sel_red;
        logic             sel_green;
        logic             sel_blue;
        logic             zero_gb;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_side;

endpackage
`default_nettype wire

// ----- rtl/bcpm_cfg.sv -----
// Configuration register file for the pixel map.
`default_nettype none
module bcpm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bcpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bcpm_pkg::t_cfg                      o_cfg
);
    import bcpm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the write; unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS:     n_cfg.brightness     = $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_CONTRAST:       n_cfg.contrast       = $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_CHANNEL_ENABLE: n_cfg.channel_enable = i_cfg_data[EN_W-1:0];
                CFG_GRAY_FORMAT:    n_cfg.gray_format    = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness     <= '0;
            r_cfg.contrast       <= '0;
            r_cfg.channel_enable <= 4'hF;
            r_cfg.gray_format    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bcpm_lane.sv -----
// One channel lane: three register stages computing the mapped value.
`default_nettype none
module bcpm_lane (
    input  wire logic                       i_clk,
    input  wire logic [bcpm_pkg::PIX_W-1:0] i_u,
    input  wire bcpm_pkg::t_cfg             i_cfg,
    output logic [bcpm_pkg::PIX_W-1:0]      o_y
);
    import bcpm_pkg::*;

    logic signed [9:0]  w_dev;
    logic signed [10:0] w_slope;
    logic signed [20:0] n_s1;
    logic signed [20:0] r_s1;
    logic signed [10:0] w_gain;
    logic signed [31:0] n_num;
    logic signed [31:0] r_num;
    logic [33:0]        w_scaled;
    logic               n_zero;
    logic               n_sat;
    logic [15:0]        n_q;
    logic               r_zero;
    logic               r_sat;
    logic [15:0]        r_q;
    logic [16:0]        w_sum;

    // Stage 1: contrast slope times (2u - 255), plus the midpoint
    assign w_dev   = $signed({1'b0, i_u, 1'b0}) - 10'sd255;
    assign w_slope = UNITY + {i_cfg.contrast[GAIN_W-1], i_cfg.contrast};
    assign n_s1    = w_slope * w_dev + MID_OFFSET;

    // Stage 2: scale by the brightness gain
    assign w_gain = UNITY + {i_cfg.brightness[GAIN_W-1], i_cfg.brightness};
    assign n_num  = r_s1 * w_gain;

    // Stage 3: clamp flags and 511*N / 2^18; in range N fits in 25 bits
    assign n_zero   = r_num[31] || (r_num == '0);
    assign n_sat    = (r_num >= MAP_DEN);
    assign w_scaled = {r_num[24:0], 9'b0} - {9'b0, r_num[24:0]};
    assign n_q      = w_scaled[33:18];

    // Divide by 255 through the reciprocal identity, exact below 2^16
    assign w_sum = {1'b0, r_q} + {9'b0, r_q[15:8]} + 17'd1;

    always_comb begin
        if (r_zero) begin
            o_y = '0;
        end else if (r_sat) begin
            o_y = '1;
        end else begin
            o_y = w_sum[15:8];
        end
    end

    // Advance the lane every cycle
    always_ff @(posedge i_clk) begin
        r_s1   <= n_s1;
        r_num  <= n_num;
        r_zero <= n_zero;
        r_sat  <= n_sat;
        r_q    <= n_q;
    end

endmodule
`default_nettype wire

// ----- rtl/brightness_contrast_pixel_map.sv -----
// Top level of the brightness/contrast pixel map.
// Usage:
//   Input: drive the four pixel fields and raise start; a pixel transfers
//   at each rising edge where start is high and busy is low. busy stays
//   low, so a new pixel may enter every clock.
//   Output: o_valid is high for exactly one cycle per pixel, with the four
//   result fields; the receiver must take it in that cycle.
//   Path: the three lane register stages (slope multiply, gain multiply,
//   clamp/scale) and the output register. Throughput: 1 pixel per clock.
//   Configuration: write index/data with i_cfg_valid; o_cfg_ready is
//   always high. Write only while no pixel is in flight.
//   Reset (synchronous, active low) clears the valid bits and restores
//   brightness 0, contrast 0, all channels enabled, RGBA format.
`default_nettype none
module brightness_contrast_pixel_map (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [bcpm_pkg::PIX_W-1:0]      i_red_in,
    input  wire logic [bcpm_pkg::PIX_W-1:0]      i_green_in,
    input  wire logic [bcpm_pkg::PIX_W-1:0]      i_blue_in,
    input  wire logic [bcpm_pkg::PIX_W-1:0]      i_alpha_in,
    output logic                                o_valid,
    output logic [bcpm_pkg::PIX_W-1:0]           o_red_out,
    output logic [bcpm_pkg::PIX_W-1:0]           o_green_out,
    output logic [bcpm_pkg::PIX_W-1:0]           o_blue_out,
    output logic [bcpm_pkg::PIX_W-1:0]           o_alpha_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bcpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bcpm_pkg::*;

    localparam int SIDE_STAGES = LATENCY - 1;

    t_cfg             w_cfg;
    t_side            w_side_in;
    t_side            r_side [SIDE_STAGES];
    logic [SIDE_STAGES-1:0] r_vld;
    logic [PIX_W-1:0] w_map_red;
    logic [PIX_W-1:0] w_map_green;
    logic [PIX_W-1:0] w_map_blue;
    logic             w_accept;
    t_side            w_last;
    logic             r_valid;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;
    logic [PIX_W-1:0] r_alpha;
    logic [PIX_W-1:0] n_red;
    logic [PIX_W-1:0] n_green;
    logic [PIX_W-1:0] n_blue;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    bcpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bcpm_lane u_lane_red (
        .i_clk (i_clk),
        .i_u   (i_red_in),
        .i_cfg (w_cfg),
        .o_y   (w_map_red)
    );

    bcpm_lane u_lane_green (
        .i_clk (i_clk),
        .i_u   (i_green_in),
        .i_cfg (w_cfg),
        .o_y   (w_map_green)
    );

    bcpm_lane u_lane_blue (
        .i_clk (i_clk),
        .i_u   (i_blue_in),
        .i_cfg (w_cfg),
        .o_y   (w_map_blue)
    );

    // Decide per channel whether the mapped value or the raw value goes out; gray format zeroes green and blue
    always_comb begin
        w_side_in.red   = i_red_in;
        w_side_in.green = i_green_in;
        w_side_in.blue  = i_blue_in;
        w_side_in.alpha = i_alpha_in;
        if (w_cfg.gray_format) begin
            w_side_in.sel_red   = w_cfg.channel_enable[EN_GRAY];
            w_side_in.sel_green = 1'b0;
            w_side_in.sel_blue  = 1'b0;
            w_side_in.zero_gb   = 1'b1;
        end else begin
            w_side_in.sel_red   = w_cfg.channel_enable[EN_RED];
            w_side_in.sel_green = w_cfg.channel_enable[EN_GREEN];
            w_side_in.sel_blue  = w_cfg.channel_enable[EN_BLUE];
            w_side_in.zero_gb   = 1'b0;
        end
    end

    // Advance the side-band line in step with the lanes
    always_ff @(posedge i_clk) begin
        r_side[0] <= w_side_in;
        for (int i = 1; i < SIDE_STAGES; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[SIDE_STAGES-2:0], w_accept};
            r_valid <= r_vld[SIDE_STAGES-1];
        end
    end

    // Select the final channel values
    assign w_last = r_side[SIDE_STAGES-1];

    always_comb begin
        n_red   = w_last.sel_red   ? w_map_red   : w_last.red;
        n_green = w_last.sel_green ? w_map_green : w_last.green;
        n_blue  = w_last.sel_blue  ? w_map_blue  : w_last.blue;
        if (w_last.zero_gb) begin
            n_green = '0;
            n_blue  = '0;
        end
    end

    // Hold the result in the output register for its one-cycle strobe
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_alpha <= w_last.alpha;
    end

    assign o_valid     = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_alpha_out = r_alpha;

    // Every result strobe comes from a matching earlier input transfer
    a_valid_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching input transfer");

    // Alpha leaves unchanged, aligned with its pixel
    a_alpha_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alpha_out == $past(i_alpha_in, LATENCY)))
        else $error("alpha misaligned with its pixel");

    // A transfer with reset kept released afterwards yields a strobe
    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) ##1 i_rst_n ##1 i_rst_n ##1 i_rst_n |=> o_valid)
        else $error("input transfer lost in the pipeline");

endmodule
`default_nettype wire
